// ===== design/fcs_pkg.sv =====
// shared types and constants of the frame checksum engine
package fcs_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned SumW  = 16;
  localparam int unsigned ModeW = 3;

  // checksum mode codes, codes six and seven behave as none
  typedef enum logic [ModeW-1:0] {
    MODE_NONE    = 3'd0,
    MODE_XOR     = 3'd1,
    MODE_ADD     = 3'd2,
    MODE_XOR_NH  = 3'd3,
    MODE_ADD_NH  = 3'd4,
    MODE_XOR_ADD = 3'd5
  } checksum_mode_e;

  // register indexes on the configuration port
  localparam logic REG_CHECKSUM_MODE   = 1'b0;
  localparam logic REG_TWO_BYTE_RESULT = 1'b1;

  // result handed from the accumulator to the output stage
  typedef struct packed {
    logic            valid;
    logic [SumW-1:0] checksum;
  } fcs_result_t;

endpackage

// ===== design/fcs_accum.sv =====
// running sum and xor accumulators with checksum formatting
module fcs_accum (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic [7:0]             frame_byte_i,
  input  logic                   is_header_i,
  input  logic                   frame_end_i,
  input  fcs_pkg::checksum_mode_e mode_i,
  input  logic                   two_byte_i,
  output fcs_pkg::fcs_result_t   result_o
);
  import fcs_pkg::*;

  logic [SumW-1:0]  sum_q, sum_d, sum_next;
  logic [ByteW-1:0] xor_q, xor_d, xor_next;
  logic             skip;
  logic [SumW-1:0]  formatted;
  logic [ByteW-1:0] mix_low;

  assign skip     = is_header_i && ((mode_i == MODE_XOR_NH) || (mode_i == MODE_ADD_NH));
  assign sum_next = skip ? sum_q : sum_q + {{(SumW-ByteW){1'b0}}, frame_byte_i};
  assign xor_next = skip ? xor_q : xor_q ^ frame_byte_i;
  assign mix_low  = sum_next[ByteW-1:0] + xor_next;

  always_comb begin
    unique case (mode_i)
      MODE_XOR, MODE_XOR_NH: formatted = {{(SumW-ByteW){1'b0}}, xor_next};
      MODE_ADD, MODE_ADD_NH: formatted = sum_next;
      MODE_XOR_ADD:          formatted = {xor_next, mix_low};
      default:               formatted = '0;
    endcase
    if (!two_byte_i) begin
      formatted[SumW-1:ByteW] = '0;
    end
  end

  // clear after the last byte of a frame
  always_comb begin
    sum_d = sum_q;
    xor_d = xor_q;
    if (step_i) begin
      sum_d = frame_end_i ? '0 : sum_next;
      xor_d = frame_end_i ? '0 : xor_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      xor_q <= '0;
    end else begin
      sum_q <= sum_d;
      xor_q <= xor_d;
    end
  end

  assign result_o.valid    = step_i && frame_end_i;
  assign result_o.checksum = formatted;

endmodule

// ===== design/fcs_out_stage.sv =====
// output register holding one finished checksum
module fcs_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fcs_pkg::fcs_result_t result_i,
  input  logic                 out_ready_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  output logic [15:0]          checksum_o
);
  import fcs_pkg::*;

  logic            valid_q, valid_d;
  logic [SumW-1:0] checksum_q;

  // a new request may enter when the slot is empty or draining this cycle
  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (result_i.valid) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result_i.valid) begin
      checksum_q <= result_i.checksum;
    end
  end

  assign out_valid_o = valid_q;
  assign checksum_o  = checksum_q;

endmodule

// ===== design/frame_checksum_engine_top.sv =====
// top level of the frame checksum engine with its configuration registers
//
// usage:
//   input channel (in_valid_i / in_ready_o) carries one frame byte per request
//   together with is_header_i and frame_end_i. every byte folds into a 16-bit
//   running sum and an 8-bit running xor, except header bytes in the modes
//   that leave the header out.
//   the request that carries frame_end_i produces one checksum on the output
//   channel (out_valid_o / out_ready_i); other bytes produce nothing.
//   latency: the checksum is valid the cycle after its last byte is accepted.
//   throughput: one byte per cycle, set by the single add and xor between the
//   input handshake and the accumulator registers.
//   stall: the output register holds one checksum; while it is full and the
//   receiver holds out_ready_i low, in_ready_o drops and no byte is accepted.
//   in_ready_o is high whenever the slot is empty or being taken this cycle.
//   reset: accumulators, output valid and both registers clear; mode is none
//   and the checksum is cut to one byte.
//   configuration: apb port, mode at address 0, two-byte flag at address 4;
//   write only while no frame is in flight.
module frame_checksum_engine_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // byte input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  frame_byte_i,
  input  logic        is_header_i,
  input  logic        frame_end_i,
  // checksum output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] checksum_o
);
  import fcs_pkg::*;

  logic [ModeW-1:0] mode_q;
  logic             two_byte_q;
  logic             cfg_write;
  logic             reg_sel;
  logic             step;
  fcs_result_t      result;

  // register file, word address picks the register
  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_NONE;
      two_byte_q <= 1'b0;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_CHECKSUM_MODE:   mode_q     <= pwdata[ModeW-1:0];
        REG_TWO_BYTE_RESULT: two_byte_q <= pwdata[0];
        default:             mode_q     <= mode_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CHECKSUM_MODE:   prdata = {{(32-ModeW){1'b0}}, mode_q};
      REG_TWO_BYTE_RESULT: prdata = {31'b0, two_byte_q};
      default:             prdata = '0;
    endcase
  end

  // a byte is taken when the output slot can absorb a possible result
  assign step = in_valid_i && in_ready_o;

  fcs_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .frame_byte_i (frame_byte_i),
    .is_header_i  (is_header_i),
    .frame_end_i  (frame_end_i),
    .mode_i       (checksum_mode_e'(mode_q)),
    .two_byte_i   (two_byte_q),
    .result_o     (result)
  );

  fcs_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .result_i    (result),
    .out_ready_i (out_ready_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .checksum_o  (checksum_o)
  );

endmodule
